FILE: hw/rtl/bda_pkg.sv
// Package for the binary to decimal ASCII converter.
// Holds shared widths, character codes and the digit count helper.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bda_pkg;

  localparam int VALUE_WIDTH_DEFAULT = 32;
  localparam int CHAR_WIDTH          = 6;
  localparam int DIGIT_WIDTH         = 4;
  localparam int STEPS_PER_STAGE     = 8;

  localparam logic [CHAR_WIDTH-1:0]  ASCII_ZERO = 6'd48;
  localparam logic [DIGIT_WIDTH-1:0] DIGIT_ADJ_MIN = 4'd5;
  localparam logic [DIGIT_WIDTH-1:0] DIGIT_ADJ_ADD = 4'd3;

  // log10(2) as a fixed ratio, good for widths up to 64 bits.
  localparam int LOG10_2_NUM = 30103;
  localparam int LOG10_2_DEN = 100000;

  // Number of decimal digits in the largest value of the given width.
  function automatic int dec_digits(input int width);
    return (width * LOG10_2_NUM) / LOG10_2_DEN + 1;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bda_channels.sv
// Handshake channel interfaces of the converter: binary numbers in,
// ASCII characters out. Depends on bda_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bda_number_if
  import bda_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface bda_text_if
  import bda_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CHAR_WIDTH-1:0] character;
  logic                  last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bda_dabble.sv
// Pipelined shift-and-add-3 binary to BCD conversion, several bits a stage.
// Depends on bda_pkg and bda_channels.
`timescale 1ns / 1ps
`default_nettype none

module bda_dabble
  import bda_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  wire                     clk,
  input  wire                     rst,
  bda_number_if.sink              number,
  output logic                    bcd_valid,
  input  wire                     bcd_ready,
  output logic [dec_digits(VALUE_WIDTH)*DIGIT_WIDTH-1:0] bcd
);

  localparam int NDIG = dec_digits(VALUE_WIDTH);
  localparam int BCDW = NDIG * DIGIT_WIDTH;
  localparam int NSTG = (VALUE_WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  logic [NSTG-1:0]        stg_vld;
  logic [NSTG-1:0]        stg_rdy;
  logic [BCDW-1:0]        stg_bcd [NSTG];
  logic [VALUE_WIDTH-1:0] stg_bin [NSTG];

  // Add three to every digit of five or more, ahead of the next shift.
  function automatic logic [BCDW-1:0] adjust(input logic [BCDW-1:0] b);
    logic [BCDW-1:0] r;
    r = b;
    for (int d = 0; d < NDIG; d++) begin
      if (r[d*DIGIT_WIDTH +: DIGIT_WIDTH] >= DIGIT_ADJ_MIN) begin
        r[d*DIGIT_WIDTH +: DIGIT_WIDTH] = r[d*DIGIT_WIDTH +: DIGIT_WIDTH] + DIGIT_ADJ_ADD;
      end
    end
    return r;
  endfunction

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    localparam int FIRST = s * STEPS_PER_STAGE;
    localparam int NSTEP = (VALUE_WIDTH - FIRST < STEPS_PER_STAGE) ?
                           (VALUE_WIDTH - FIRST) : STEPS_PER_STAGE;

    logic                   src_vld;
    logic [BCDW-1:0]        src_bcd;
    logic [VALUE_WIDTH-1:0] src_bin;
    logic [BCDW-1:0]        bcd_next;
    logic [VALUE_WIDTH-1:0] bin_next;

    if (s == 0) begin : g_src_in
      assign src_vld = number.valid;
      assign src_bcd = '0;
      assign src_bin = number.value;
    end else begin : g_src_stage
      assign src_vld = stg_vld[s-1];
      assign src_bcd = stg_bcd[s-1];
      assign src_bin = stg_bin[s-1];
    end

    if (s == NSTG - 1) begin : g_rdy_last
      assign stg_rdy[s] = !stg_vld[s] || bcd_ready;
    end else begin : g_rdy_mid
      assign stg_rdy[s] = !stg_vld[s] || stg_rdy[s+1];
    end

    always_comb begin
      bcd_next = src_bcd;
      bin_next = src_bin;
      for (int i = 0; i < NSTEP; i++) begin
        bcd_next = adjust(bcd_next);
        bcd_next = {bcd_next[BCDW-2:0], bin_next[VALUE_WIDTH-1]};
        bin_next = {bin_next[VALUE_WIDTH-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_vld[s] <= 1'b0;
      end else if (stg_rdy[s]) begin
        stg_vld[s] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (stg_rdy[s]) begin
        stg_bcd[s] <= bcd_next;
        stg_bin[s] <= bin_next;
      end
    end
  end

  assign number.ready = stg_rdy[0];
  assign bcd_valid    = stg_vld[NSTG-1];
  assign bcd          = stg_bcd[NSTG-1];

`ifndef SYNTHESIS
  // Every input bit must have been shifted into the BCD word by the last stage.
  a_bin_consumed: assert property (@(posedge clk) disable iff (rst)
    stg_vld[NSTG-1] |-> (stg_bin[NSTG-1] == '0))
    else $error("binary bits left over after the last conversion stage");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/binary_to_decimal_ascii.sv
// Top level of the binary to decimal ASCII converter.
// Depends on bda_pkg, bda_channels and bda_dabble.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Role    Handshake     Payload
// number    sink    valid/ready   value     (VALUE_WIDTH bits, unsigned)
// text      source  valid/ready   character (6 bits, ASCII '0'..'9'), last
//
// Path: a number passes ceil(VALUE_WIDTH/8) conversion stages, one
// leading-digit stage and then the character register.
// The character register emits one character a cycle while text is ready,
// and a number has 1 to 10 digits at the default width.
// Reset clears only the valid bits of the stages. A stall on the text side
// freezes the character register and backs up the pipeline stage by stage;
// nothing is dropped or sent twice.

module binary_to_decimal_ascii
  import bda_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  wire         clk,
  input  wire         rst,
  bda_number_if.sink  number,
  bda_text_if.source  text
);

  localparam int NDIG = dec_digits(VALUE_WIDTH);
  localparam int BCDW = NDIG * DIGIT_WIDTH;
  localparam int IDXW = $clog2(NDIG);

  // Packed BCD word, one digit per entry, least significant at index zero.
  typedef logic [NDIG-1:0][DIGIT_WIDTH-1:0] bcd_t;

  // Conversion pipeline output.
  logic      dab_vld;
  logic      dab_rdy;
  logic [BCDW-1:0] dab_bcd;

  // Leading digit stage: finds the most significant nonzero digit.
  logic            lead_vld;
  logic            lead_rdy;
  bcd_t            lead_bcd;
  logic [IDXW-1:0] lead_idx;
  logic [IDXW-1:0] lead_idx_next;
  bcd_t            dab_digits;

  // Character register: walks from the leading digit down to digit zero.
  logic            ser_vld;
  logic            ser_take;
  bcd_t            ser_bcd;
  logic [IDXW-1:0] ser_idx;
  logic            ser_end;

  bda_dabble #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dabble (
    .clk       (clk),
    .rst       (rst),
    .number    (number),
    .bcd_valid (dab_vld),
    .bcd_ready (dab_rdy),
    .bcd       (dab_bcd)
  );

  assign dab_digits = dab_bcd;

  // The highest nonzero digit wins; an all-zero number leads at digit zero,
  // which gives the single character '0'.
  always_comb begin
    lead_idx_next = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (dab_digits[d] != '0) begin
        lead_idx_next = IDXW'(d);
      end
    end
  end

  assign lead_rdy = !lead_vld || ser_take;
  assign dab_rdy  = lead_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_vld <= 1'b0;
    end else if (lead_rdy) begin
      lead_vld <= dab_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (lead_rdy) begin
      lead_bcd <= dab_digits;
      lead_idx <= lead_idx_next;
    end
  end

  // The register loads the next number once it is empty or its final
  // character is being taken.
  assign ser_end  = (ser_idx == '0);
  assign ser_take = !ser_vld || (text.ready && ser_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_vld <= 1'b0;
    end else if (ser_take) begin
      ser_vld <= lead_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_take) begin
      ser_bcd <= lead_bcd;
      ser_idx <= lead_idx;
    end else if (text.ready) begin
      ser_idx <= ser_idx - IDXW'(1);
    end
  end

  assign text.valid     = ser_vld;
  assign text.character = ASCII_ZERO + {{(CHAR_WIDTH-DIGIT_WIDTH){1'b0}}, ser_bcd[ser_idx]};
  assign text.last      = ser_end;

`ifndef SYNTHESIS
  // The leading digit of a number with more than one digit is never zero.
  a_lead_nonzero: assert property (@(posedge clk) disable iff (rst)
    (lead_vld && (lead_idx != '0)) |-> (lead_bcd[lead_idx] != '0))
    else $error("leading digit index points at a zero digit");

  // The digit index stays within the BCD word.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    ser_vld |-> (ser_idx <= IDXW'(NDIG - 1)))
    else $error("character index beyond the digit count");

  // A stalled character keeps its place in the number.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (ser_vld && !text.ready) |=> (ser_vld && $stable(ser_idx) && $stable(ser_bcd)))
    else $error("character register moved while stalled");
`endif

endmodule

`default_nettype wire
